// ===== design/b74_pkg.sv =====
// Shared types, constants and character tables of the base-74 text codec.
package b74_pkg;

   localparam int MAX_DIGITS_DEF = 15;
   localparam int RADIX          = 74;
   localparam int NUM_W          = 64;
   localparam int DIGIT_W        = 7;
   localparam int CHAR_W         = 8;
   localparam int COUNT_W        = 4;
   localparam int LEN_MAX        = 11;
   localparam int DIV_BITS       = 8;
   localparam int DIV_CYCLES     = NUM_W / DIV_BITS;
   localparam int STEP_W         = $clog2(DIV_CYCLES);

   typedef logic [1:0] func_type;
   localparam func_type FUNC_ENC = 2'd0;
   localparam func_type FUNC_DEC = 2'd1;
   localparam func_type FUNC_LEN = 2'd2;

   typedef struct packed {
      logic     load_enc;
      logic     load_dec;
      logic     load_len;
      logic     div_step;
      logic     dec_mul;
      logic     dec_add;
      logic     len_step;
      logic     emit;
      func_type emit_kind;
      logic     emit_last;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic len_more;
   } status_type;

   typedef struct packed {
      logic               ok;
      logic [DIGIT_W-1:0] digit;
   } lookup_type;

   // map an alphabet position to its ASCII code
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      begin
         case (d) inside
            [7'd0:7'd9]:   c = 8'({1'b0, d} + 8'd48);
            [7'd10:7'd35]: c = 8'({1'b0, d} + 8'd87);
            [7'd36:7'd61]: c = 8'({1'b0, d} + 8'd29);
            7'd62:         c = 8'h20;
            7'd63:         c = 8'h2d;
            7'd64:         c = 8'h28;
            7'd65:         c = 8'h29;
            7'd66:         c = 8'h2e;
            7'd67:         c = 8'h2b;
            7'd68:         c = 8'h2a;
            7'd69:         c = 8'h2f;
            7'd70:         c = 8'h3f;
            7'd71:         c = 8'h3c;
            7'd72:         c = 8'h3e;
            7'd73:         c = 8'h5f;
            default:       c = 8'h30;
         endcase
         return c;
      end
   endfunction

   // map an ASCII code to its alphabet position; unknown codes give digit zero
   function automatic lookup_type char_to_digit(input logic [CHAR_W-1:0] c);
      lookup_type r;
      begin
         r.ok = 1'b1;
         case (c) inside
            [8'h30:8'h39]: r.digit = 7'(c - 8'd48);
            [8'h61:8'h7a]: r.digit = 7'(c - 8'd87);
            [8'h41:8'h5a]: r.digit = 7'(c - 8'd29);
            8'h20:         r.digit = 7'd62;
            8'h2d:         r.digit = 7'd63;
            8'h28:         r.digit = 7'd64;
            8'h29:         r.digit = 7'd65;
            8'h2e:         r.digit = 7'd66;
            8'h2b:         r.digit = 7'd67;
            8'h2a:         r.digit = 7'd68;
            8'h2f:         r.digit = 7'd69;
            8'h3f:         r.digit = 7'd70;
            8'h3c:         r.digit = 7'd71;
            8'h3e:         r.digit = 7'd72;
            8'h5f:         r.digit = 7'd73;
            default: begin
               r.ok    = 1'b0;
               r.digit = 7'd0;
            end
         endcase
         return r;
      end
   endfunction

   // powers of the radix, 74^1 to 74^10
   function automatic logic [NUM_W-1:0] radix_power(input logic [COUNT_W-1:0] n);
      logic [NUM_W-1:0] p;
      begin
         case (n)
            4'd1:    p = 64'd74;
            4'd2:    p = 64'd5476;
            4'd3:    p = 64'd405224;
            4'd4:    p = 64'd29986576;
            4'd5:    p = 64'd2219006624;
            4'd6:    p = 64'd164206490176;
            4'd7:    p = 64'd12151280273024;
            4'd8:    p = 64'd899194740203776;
            4'd9:    p = 64'd66540410775079424;
            4'd10:   p = 64'd4923990397355877376;
            default: p = '1;
         endcase
         return p;
      end
   endfunction

endpackage

// ===== design/b74_channels.sv =====
// Request and response channel interfaces of the base-74 text codec.
interface b74_req_if
   import b74_pkg::*;
   ();
   logic               valid;
   logic               ready;
   func_type           func;
   logic [NUM_W-1:0]   number_in;
   logic [COUNT_W-1:0] digit_count;
   logic [CHAR_W-1:0]  char_in;
   logic               last_char;

   modport source (output valid, func, number_in, digit_count, char_in, last_char,
                   input ready);
   modport sink (input valid, func, number_in, digit_count, char_in, last_char,
                 output ready);
endinterface

interface b74_rsp_if
   import b74_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  char_out;
   logic [NUM_W-1:0]   value_out;
   logic [COUNT_W-1:0] length_out;
   logic               bad_char;
   logic               last_out;

   modport source (output valid, char_out, value_out, length_out, bad_char, last_out,
                   input ready);
   modport sink (input valid, char_out, value_out, length_out, bad_char, last_out,
                 output ready);
endinterface

// ===== design/b74_ctrl.sv =====
// Controller state machine of the base-74 text codec.
module b74_ctrl
   import b74_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  func_type           req_func,
   input  logic [COUNT_W-1:0] req_digit_count,
   input  logic               req_last_char,
   input  status_type         status,
   output cmd_type            cmd
);

   localparam int CAP = (MAX_DIGITS > 15) ? 15 : MAX_DIGITS;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DIV      = 3'd1;
   localparam logic [2:0] S_EMIT_ENC = 3'd2;
   localparam logic [2:0] S_DEC_MUL  = 3'd3;
   localparam logic [2:0] S_DEC_ADD  = 3'd4;
   localparam logic [2:0] S_LEN      = 3'd5;
   localparam logic [2:0] S_EMIT     = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   func_type           kind_ff, kind_in;
   logic               last_ff, last_in;
   logic [COUNT_W-1:0] capped;

   assign capped    = (req_digit_count > COUNT_W'(CAP)) ? COUNT_W'(CAP) : req_digit_count;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FUNC_ENC: begin
                     if (capped != '0) begin
                        cmd.load_enc = 1'b1;
                        left_in      = capped;
                        step_in      = '0;
                        state_in     = S_DIV;
                     end
                  end
                  FUNC_DEC: begin
                     cmd.load_dec = 1'b1;
                     last_in      = req_last_char;
                     state_in     = S_DEC_MUL;
                  end
                  FUNC_LEN: begin
                     cmd.load_len = 1'b1;
                     state_in     = S_LEN;
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_CYCLES - 1)) begin
               state_in = S_EMIT_ENC;
            end
         end
         S_EMIT_ENC: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = FUNC_ENC;
               cmd.emit_last = (left_ff == COUNT_W'(1));
               left_in       = left_ff - 1'b1;
               state_in      = (left_ff == COUNT_W'(1)) ? S_IDLE : S_DIV;
            end
         end
         S_DEC_MUL: begin
            cmd.dec_mul = 1'b1;
            state_in    = S_DEC_ADD;
         end
         S_DEC_ADD: begin
            cmd.dec_add = 1'b1;
            kind_in     = FUNC_DEC;
            state_in    = last_ff ? S_EMIT : S_IDLE;
         end
         S_LEN: begin
            cmd.len_step = 1'b1;
            if (!status.len_more) begin
               kind_in  = FUNC_LEN;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = kind_ff;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         left_ff  <= '0;
         kind_ff  <= FUNC_ENC;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         left_ff  <= left_in;
         kind_ff  <= kind_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== design/b74_datapath.sv =====
// Datapath of the base-74 text codec: divider, decode accumulator, length search, output register.
module b74_datapath
   import b74_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [NUM_W-1:0]  req_number_in,
   input  logic [CHAR_W-1:0] req_char_in,
   input  cmd_type           cmd,
   output status_type        status,
   b74_rsp_if.source         rsp
);

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [DIGIT_W-1:0] digit_ff;
   logic [NUM_W-1:0]   prod_ff;
   logic [NUM_W-1:0]   weight_ff;
   logic [NUM_W-1:0]   sum_ff;
   logic               bad_ff;
   logic [COUNT_W-1:0] idx_ff;
   lookup_type         lookup;

   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic [NUM_W-1:0]   rsp_value_ff;
   logic [COUNT_W-1:0] rsp_length_ff;
   logic               rsp_bad_ff;
   logic               rsp_last_ff;

   assign lookup = char_to_digit(req_char_in);

   // eight restoring division steps by the radix on the top byte
   always_comb begin
      logic [DIGIT_W:0]      trial;
      logic [DIV_BITS-1:0]   qbits;
      logic [DIGIT_W-1:0]    r;
      r     = rem_ff;
      qbits = '0;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial = {r, num_ff[NUM_W-1-j]};
         if (trial >= (DIGIT_W+1)'(RADIX)) begin
            trial              = trial - (DIGIT_W+1)'(RADIX);
            qbits[DIV_BITS-1-j] = 1'b1;
         end
         r = trial[DIGIT_W-1:0];
      end
      rem_in = r;
      num_in = {num_ff[NUM_W-DIV_BITS-1:0], qbits};
   end

   assign status.slot_free = !rsp_valid_ff || rsp.ready;
   assign status.len_more  = (idx_ff < COUNT_W'(LEN_MAX)) && (num_ff >= radix_power(idx_ff));

   always_ff @(posedge clock) begin
      if (cmd.load_enc || cmd.load_len) begin
         num_ff <= req_number_in;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
      end
      if (cmd.load_enc || (cmd.emit && cmd.emit_kind == FUNC_ENC)) begin
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
      end
      if (cmd.load_len) begin
         idx_ff <= COUNT_W'(1);
      end else if (cmd.len_step && status.len_more) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.load_dec) begin
         digit_ff <= lookup.digit;
      end
      if (cmd.dec_mul) begin
         prod_ff <= weight_ff * {{(NUM_W-DIGIT_W){1'b0}}, digit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         weight_ff <= NUM_W'(1);
         bad_ff    <= 1'b0;
      end else if (cmd.emit && cmd.emit_kind == FUNC_DEC) begin
         sum_ff    <= '0;
         weight_ff <= NUM_W'(1);
         bad_ff    <= 1'b0;
      end else begin
         if (cmd.load_dec && !lookup.ok) begin
            bad_ff <= 1'b1;
         end
         if (cmd.dec_mul) begin
            weight_ff <= (weight_ff << 6) + (weight_ff << 3) + (weight_ff << 1);
         end
         if (cmd.dec_add) begin
            sum_ff <= sum_ff + prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff   <= '0;
         rsp_value_ff  <= '0;
         rsp_length_ff <= '0;
         rsp_bad_ff    <= 1'b0;
         rsp_last_ff   <= cmd.emit_last;
         case (cmd.emit_kind)
            FUNC_ENC: rsp_char_ff <= digit_to_char(rem_ff);
            FUNC_DEC: begin
               rsp_value_ff <= sum_ff;
               rsp_bad_ff   <= bad_ff;
            end
            FUNC_LEN: rsp_length_ff <= idx_ff;
            default: ;
         endcase
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.char_out   = rsp_char_ff;
   assign rsp.value_out  = rsp_value_ff;
   assign rsp.length_out = rsp_length_ff;
   assign rsp.bad_char   = rsp_bad_ff;
   assign rsp.last_out   = rsp_last_ff;

endmodule

// ===== design/base74_text_codec.sv =====
// Top level of the base-74 text codec: controller, datapath and checks.
//
// Words arrive on req and results leave on rsp, both valid/ready; a word moves
// at a clock edge with valid and ready high. One request is worked at a time:
// req.ready is high only while the controller is idle.
// Encode (func 0): digit_count characters (at most MAX_DIGITS), least
// significant first, the last marked by last_out. The radix-74 divider
// retires 8 quotient bits per cycle, then each digit loads the output register.
// Decode (func 1): per character, digit lookup, multiply by the place weight,
// accumulate; a character flagged last gives one word with the value.
// Length query (func 2): one compare against a power of 74 per cycle, then one
// result word.
// Unused func code and encode with zero digit count: dropped, no result.
// The output register holds a word while rsp.ready is low; the block may take
// the next request meanwhile, and stalls only when it must load a new result.
// Reset clears the decode accumulator and bad-character flag and sets the place weight to one.
module base74_text_codec
   import b74_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input logic        clock,
   input logic        reset,
   b74_req_if.sink    req,
   b74_rsp_if.source  rsp
);

   cmd_type    cmd;
   status_type status;

   b74_ctrl #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req.valid),
      .req_ready       (req.ready),
      .req_func        (req.func),
      .req_digit_count (req.digit_count),
      .req_last_char   (req.last_char),
      .status          (status),
      .cmd             (cmd)
   );

   b74_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_number_in (req.number_in),
      .req_char_in   (req.char_in),
      .cmd           (cmd),
      .status        (status),
      .rsp           (rsp)
   );

   a_mid_word_is_char: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.last_out |-> rsp.char_out != 8'd0)
      else $error("non-final result word carries no character");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.length_out != 4'd0 |->
         rsp.length_out <= 4'(LEN_MAX) && rsp.char_out == 8'd0 && rsp.value_out == '0)
      else $error("length result out of range or mixed with other fields");

   a_len_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.func == FUNC_LEN |=> !req.ready)
      else $error("length query accepted without search cycle");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.slot_free)
      else $error("result loaded over a word not yet taken");

endmodule
